### rtl/core/assert_macros.svh
// assertion helpers included by track_mode_quality_classifier
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: lbl");

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition: lbl");

`endif

### rtl/core/tmqc_pkg.sv
`default_nettype none

package tmqc_pkg;

  // input transaction
  typedef struct packed {
    logic [11:0] hit_mask;
    logic        track_valid;
    logic [5:0]  model_quality;
  } tmqc_req_t;

  // result transaction
  typedef struct packed {
    logic [3:0] station_mode;
    logic [3:0] category_mode;
    logic [3:0] track_quality;
  } tmqc_res_t;

  // per-station hit summary handed to the category rules
  typedef struct packed {
    logic c0;          // site 11
    logic c11;         // site 0
    logic c12;         // site 1
    logic st1_a;       // sites 0, 9
    logic st1_b;       // sites 1, 5
    logic csc_ge1;     // at least one of sites 2, 3, 4
    logic csc_ge2;     // at least two of sites 2, 3, 4
    logic any234_ge1;  // at least one of stations 2, 3, 4
    logic any234_ge2;  // at least two of stations 2, 3, 4
    logic any34_ge1;   // station 3 or station 4
  } tmqc_flags_t;

  // station mode bit positions
  localparam int unsigned StBitS1 = 3;
  localparam int unsigned StBitS2 = 2;
  localparam int unsigned StBitS3 = 1;
  localparam int unsigned StBitS4 = 0;

  // category codes
  localparam logic [3:0] CatSingle    = 4'd12;
  localparam logic [3:0] CatDouble    = 4'd8;
  localparam logic [3:0] CatTriple    = 4'd4;
  localparam logic [3:0] CatSingleHit = 4'd0;

  // score band thresholds
  localparam logic [5:0] ThrS3 = 6'd51;
  localparam logic [5:0] ThrS2 = 6'd39;
  localparam logic [5:0] ThrS1 = 6'd31;
  localparam logic [5:0] ThrD2 = 6'd31;
  localparam logic [5:0] ThrD1 = 6'd23;
  localparam logic [5:0] ThrD0 = 6'd15;
  localparam logic [5:0] ThrT2 = 6'd15;
  localparam logic [5:0] ThrT1 = 6'd11;
  localparam logic [5:0] ThrT0 = 6'd7;
  localparam logic [5:0] ThrH1 = 6'd7;
  localparam logic [5:0] ThrH0 = 6'd3;

endpackage

`default_nettype wire

### rtl/core/tmqc_category.sv
`default_nettype none

module tmqc_category (
  input  tmqc_pkg::tmqc_flags_t flags_i,
  output logic [3:0]            category_o
);
  import tmqc_pkg::*;

  logic single_hit;
  logic double_hit;

  // single-track rule set
  assign single_hit = (flags_i.c12 && flags_i.csc_ge1) ||
                      (flags_i.st1_b && flags_i.csc_ge1 && flags_i.any234_ge2) ||
                      (flags_i.c11 && flags_i.csc_ge1 && flags_i.any234_ge2) ||
                      (flags_i.st1_a && flags_i.csc_ge2) ||
                      (flags_i.c0 && flags_i.c11 && flags_i.any34_ge1) ||
                      (flags_i.c0 && flags_i.csc_ge1 && flags_i.any234_ge2);

  // double-track rule set
  assign double_hit = (flags_i.c12 && flags_i.any234_ge1) ||
                      (flags_i.c11 && flags_i.any234_ge1) ||
                      (flags_i.st1_b && flags_i.csc_ge1) ||
                      (flags_i.st1_a && flags_i.csc_ge1) ||
                      (flags_i.c0 && flags_i.c11 && flags_i.any234_ge1) ||
                      (flags_i.c0 && flags_i.csc_ge1);

  // priority: single, double, triple, single hit
  always_comb begin
    if (single_hit) begin
      category_o = CatSingle;
    end else if (double_hit) begin
      category_o = CatDouble;
    end else if (flags_i.csc_ge2) begin
      category_o = CatTriple;
    end else begin
      category_o = CatSingleHit;
    end
  end

endmodule

`default_nettype wire

### rtl/core/track_mode_quality_classifier.sv
// Track mode and quality classifier. A transaction is taken at every rising
// edge with start_i high; busy_o is always low, so a new track can enter in
// every cycle. Each track is on res_o with done_o high for exactly one cycle,
// once it has passed the three register stages, in the order taken; the
// receiver has no way to hold results back. The three register stages are
// hit summary with station mode, category rules, and quality banding.
`default_nettype none
`include "assert_macros.svh"

module track_mode_quality_classifier (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  tmqc_pkg::tmqc_req_t req_i,
  output logic                busy_o,
  output logic                done_o,
  output tmqc_pkg::tmqc_res_t res_o
);
  import tmqc_pkg::*;

  // stage 1: hit summary
  logic        v1_q;
  tmqc_flags_t flags_d, flags_q;
  logic [3:0]  smode_d, smode1_q;
  logic        tv1_q;
  logic [5:0]  mq1_q;

  // stage 2: category
  logic        v2_q;
  logic [3:0]  cat_d, cat2_q;
  logic [3:0]  smode2_q;
  logic        tv2_q;
  logic [5:0]  mq2_q;

  // stage 3: quality, output register
  logic        v3_q;
  tmqc_res_t   res_d, res_q;

  logic [11:0] m;
  logic        st2, st3, st4;
  logic [1:0]  csc_cnt;
  logic [1:0]  any234_cnt;
  logic        start_ok;

  assign busy_o   = 1'b0;
  assign start_ok = start_i && !busy_o;
  assign m        = req_i.hit_mask;

  // station grouping of the site mask
  assign st2        = m[2] | m[10] | m[6];
  assign st3        = m[3] | m[7];
  assign st4        = m[4] | m[8];
  assign csc_cnt    = {1'b0, m[2]} + {1'b0, m[3]} + {1'b0, m[4]};
  assign any234_cnt = {1'b0, st2} + {1'b0, st3} + {1'b0, st4};

  always_comb begin
    smode_d          = '0;
    smode_d[StBitS1] = m[0] | m[9] | m[1] | m[5] | m[11];
    smode_d[StBitS2] = st2;
    smode_d[StBitS3] = st3;
    smode_d[StBitS4] = st4;

    flags_d.c0         = m[11];
    flags_d.c11        = m[0];
    flags_d.c12        = m[1];
    flags_d.st1_a      = m[0] | m[9];
    flags_d.st1_b      = m[1] | m[5];
    flags_d.csc_ge1    = csc_cnt != 2'd0;
    flags_d.csc_ge2    = csc_cnt[1];
    flags_d.any234_ge1 = any234_cnt != 2'd0;
    flags_d.any234_ge2 = any234_cnt[1];
    flags_d.any34_ge1  = st3 | st4;
  end

  // category rules
  tmqc_category u_category (
    .flags_i    (flags_q),
    .category_o (cat_d)
  );

  // quality banding within the category
  always_comb begin
    res_d.station_mode  = smode2_q;
    res_d.category_mode = cat2_q;
    res_d.track_quality = 4'd0;
    if (tv2_q && !$onehot0(smode2_q)) begin
      case (cat2_q)
        CatSingleHit: begin
          if (mq2_q <= ThrH0) begin
            res_d.track_quality = 4'd1;
          end else if (mq2_q <= ThrH1) begin
            res_d.track_quality = 4'd2;
          end else begin
            res_d.track_quality = 4'd3;
          end
        end
        CatTriple: begin
          if (mq2_q > ThrT2) begin
            res_d.track_quality = 4'd7;
          end else if (mq2_q > ThrT1) begin
            res_d.track_quality = 4'd6;
          end else if (mq2_q > ThrT0) begin
            res_d.track_quality = 4'd5;
          end else begin
            res_d.track_quality = 4'd4;
          end
        end
        CatDouble: begin
          res_d.track_quality = 4'd8;
          if (smode2_q == 4'd9 || smode2_q == 4'd10 || smode2_q == 4'd12) begin
            if (mq2_q > ThrD2) begin
              res_d.track_quality = 4'd11;
            end else if (mq2_q > ThrD1) begin
              res_d.track_quality = 4'd10;
            end else if (mq2_q > ThrD0) begin
              res_d.track_quality = 4'd9;
            end
          end
        end
        default: begin
          res_d.track_quality = 4'd12;
          if (smode2_q == 4'd11 || smode2_q == 4'd13 ||
              smode2_q == 4'd14 || smode2_q == 4'd15) begin
            if (mq2_q > ThrS3) begin
              res_d.track_quality = 4'd15;
            end else if (mq2_q > ThrS2) begin
              res_d.track_quality = 4'd14;
            end else if (mq2_q > ThrS1) begin
              res_d.track_quality = 4'd13;
            end
          end
        end
      endcase
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_ok;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    flags_q  <= flags_d;
    smode1_q <= smode_d;
    tv1_q    <= req_i.track_valid;
    mq1_q    <= req_i.model_quality;
    cat2_q   <= cat_d;
    smode2_q <= smode1_q;
    tv2_q    <= tv1_q;
    mq2_q    <= mq1_q;
    res_q    <= res_d;
  end

  assign done_o = v3_q;
  assign res_o  = res_q;

  // checks
  `ASSERT_CLK(a_stage12, clk_i, rst_ni, v1_q |=> v2_q)
  `ASSERT_CLK(a_stage23, clk_i, rst_ni, v2_q |=> done_o)
  `ASSERT_CLK(a_band_cat, clk_i, rst_ni, (done_o && res_o.track_quality != 4'd0) |-> (res_o.track_quality[3:2] == res_o.category_mode[3:2]))
  `ASSERT_NEVER(a_one_station, clk_i, rst_ni, done_o && $onehot0(res_o.station_mode) && res_o.track_quality != 4'd0)

endmodule

`default_nettype wire

### dv/tb_track_mode_quality_classifier.sv
`timescale 1ns / 100ps

module tb_track_mode_quality_classifier;
  import tmqc_pkg::*;

  localparam int unsigned HalfPeriod    = 5;
  localparam int unsigned ResetCycles   = 8;
  localparam int unsigned ItemsPerPhase = 250;
  localparam int unsigned NumPhases     = 4;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned WatchdogLimit = 2000;

  // one row of the directed stimulus table
  typedef struct {
    tmqc_req_t trk;
    bit        typed;
    tmqc_res_t res;
  } track_row_t;

  logic      clk_i   = 1'b0;
  logic      rst_ni  = 1'b0;
  logic      start_i = 1'b0;
  tmqc_req_t req_i   = '0;
  logic      busy_o;
  logic      done_o;
  tmqc_res_t res_o;

  tmqc_res_t   expected_class_q[$];
  track_row_t  directed_tracks[$];
  tmqc_res_t   arrived_class;
  int unsigned error_count = 0;
  int unsigned idle_pct    = 0;
  int unsigned quiet_count = 0;

  always #(HalfPeriod) clk_i = ~clk_i;

  track_mode_quality_classifier dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .res_o   (res_o)
  );

  // station mode, category and banded quality of one track
  function automatic tmqc_res_t classify_track(input tmqc_req_t trk);
    tmqc_res_t   cls;
    logic [11:0] m;
    logic        st1a, st1b, st2, st3, st4, c0, c11, c12;
    int unsigned csc, any234, any34, nst;
    logic        is_single, is_double;
    logic [5:0]  q;
    m    = trk.hit_mask;
    q    = trk.model_quality;
    st1a = m[0] | m[9];
    st1b = m[1] | m[5];
    st2  = m[2] | m[10] | m[6];
    st3  = m[3] | m[7];
    st4  = m[4] | m[8];
    c0   = m[11];
    c11  = m[0];
    c12  = m[1];
    csc    = int'(m[2]) + int'(m[3]) + int'(m[4]);
    any234 = int'(st2) + int'(st3) + int'(st4);
    any34  = int'(st3) + int'(st4);

    cls.station_mode = '0;
    cls.station_mode[StBitS1] = st1a | st1b | c0;
    cls.station_mode[StBitS2] = st2;
    cls.station_mode[StBitS3] = st3;
    cls.station_mode[StBitS4] = st4;
    nst = $countones(cls.station_mode);

    // rule sets in priority order
    is_single = (c12 && csc >= 1) || (st1b && csc >= 1 && any234 >= 2) ||
                (c11 && csc >= 1 && any234 >= 2) || (st1a && csc >= 2) ||
                (c0 && c11 && any34 >= 1) || (c0 && csc >= 1 && any234 >= 2);
    is_double = (c12 && any234 >= 1) || (c11 && any234 >= 1) ||
                (st1b && csc >= 1) || (st1a && csc >= 1) ||
                (c0 && c11 && any234 >= 1) || (c0 && csc >= 1);
    if (is_single) begin
      cls.category_mode = CatSingle;
    end else if (is_double) begin
      cls.category_mode = CatDouble;
    end else if (csc >= 2) begin
      cls.category_mode = CatTriple;
    end else begin
      cls.category_mode = CatSingleHit;
    end

    // quality: category base plus score band
    cls.track_quality = '0;
    if (trk.track_valid && nst >= 2) begin
      case (cls.category_mode)
        CatSingleHit: begin
          if (q <= ThrH0) cls.track_quality = 4'd1;
          else if (q <= ThrH1) cls.track_quality = 4'd2;
          else cls.track_quality = 4'd3;
        end
        CatTriple: begin
          cls.track_quality = CatTriple;
          if (q > ThrT2) cls.track_quality = CatTriple + 4'd3;
          else if (q > ThrT1) cls.track_quality = CatTriple + 4'd2;
          else if (q > ThrT0) cls.track_quality = CatTriple + 4'd1;
        end
        CatDouble: begin
          // upper bands only for station 1 plus exactly one other station
          cls.track_quality = CatDouble;
          if (cls.station_mode[StBitS1] && nst == 2) begin
            if (q > ThrD2) cls.track_quality = CatDouble + 4'd3;
            else if (q > ThrD1) cls.track_quality = CatDouble + 4'd2;
            else if (q > ThrD0) cls.track_quality = CatDouble + 4'd1;
          end
        end
        default: begin
          // upper bands only for station 1 plus at least two others
          cls.track_quality = CatSingle;
          if (cls.station_mode[StBitS1] && nst >= 3) begin
            if (q > ThrS3) cls.track_quality = CatSingle + 4'd3;
            else if (q > ThrS2) cls.track_quality = CatSingle + 4'd2;
            else if (q > ThrS1) cls.track_quality = CatSingle + 4'd1;
          end
        end
      endcase
    end
    return cls;
  endfunction

  // random track: dense, sparse or medium masks, scores clustered at band edges
  function automatic tmqc_req_t random_track();
    tmqc_req_t  trk;
    logic [5:0] thr;
    case ($urandom_range(2))
      0: trk.hit_mask = 12'($urandom_range(4095));
      1: begin
        trk.hit_mask = '0;
        repeat ($urandom_range(1, 3)) trk.hit_mask[$urandom_range(11)] = 1'b1;
      end
      default: trk.hit_mask = 12'($urandom_range(4095) & $urandom_range(4095));
    endcase
    trk.track_valid = ($urandom_range(9) != 0);
    if ($urandom_range(1) == 0) begin
      trk.model_quality = 6'($urandom_range(63));
    end else begin
      case ($urandom_range(7))
        0: thr = ThrH0;
        1: thr = ThrH1;
        2: thr = ThrT1;
        3: thr = ThrT2;
        4: thr = ThrD1;
        5: thr = ThrD2;
        6: thr = ThrS2;
        default: thr = ThrS3;
      endcase
      trk.model_quality = thr + 6'($urandom_range(1));
    end
    return trk;
  endfunction

  task automatic add_row(input logic [11:0] mask, input logic valid, input logic [5:0] q,
                         input bit typed, input logic [3:0] smode, input logic [3:0] cat,
                         input logic [3:0] qual);
    track_row_t row;
    row.trk.hit_mask          = mask;
    row.trk.track_valid       = valid;
    row.trk.model_quality     = q;
    row.typed                 = typed;
    row.res.station_mode      = smode;
    row.res.category_mode     = cat;
    row.res.track_quality     = qual;
    directed_tracks.insert(directed_tracks.size(), row);
  endtask

  // drive one transaction after a random gap, record its expected class on acceptance
  task automatic send_track(input tmqc_req_t trk, input tmqc_res_t cls);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= trk;
    do @(posedge clk_i); while (busy_o);
    expected_class_q.insert(expected_class_q.size(), cls);
  endtask

  // compare each result with the oldest outstanding transaction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_class_q.size() == 0) begin
        $error("res_o: result with no transaction outstanding, actual %h", res_o);
        error_count++;
      end else begin
        arrived_class = expected_class_q.pop_front();
        if (res_o.station_mode !== arrived_class.station_mode) begin
          $error("station_mode: expected %0d, actual %0d",
                 arrived_class.station_mode, res_o.station_mode);
          error_count++;
        end
        if (res_o.category_mode !== arrived_class.category_mode) begin
          $error("category_mode: expected %0d, actual %0d",
                 arrived_class.category_mode, res_o.category_mode);
          error_count++;
        end
        if (res_o.track_quality !== arrived_class.track_quality) begin
          $error("track_quality: expected %0d, actual %0d",
                 arrived_class.track_quality, res_o.track_quality);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction in either direction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        quiet_count = 0;
      end else begin
        quiet_count++;
      end
      if (quiet_count >= WatchdogLimit) begin
        $display("tb_track_mode_quality_classifier: done, errors");
        $finish;
      end
    end
  end

  initial begin
    tmqc_res_t cls;

    // typed rows: empty, full, invalid, lowest score, single station
    add_row(12'h000, 1'b1, 6'd63, 1'b1, 4'd0,  CatSingleHit, 4'd0);
    add_row(12'hfff, 1'b1, 6'd63, 1'b1, 4'd15, CatSingle,    4'd15);
    add_row(12'hfff, 1'b0, 6'd63, 1'b1, 4'd15, CatSingle,    4'd0);
    add_row(12'hfff, 1'b1, 6'd0,  1'b1, 4'd15, CatSingle,    4'd12);
    add_row(12'h001, 1'b1, 6'd63, 1'b1, 4'd8,  CatSingleHit, 4'd0);
    add_row(12'h004, 1'b1, 6'd63, 1'b1, 4'd4,  CatSingleHit, 4'd0);
    add_row(12'h008, 1'b1, 6'd63, 1'b1, 4'd2,  CatSingleHit, 4'd0);
    add_row(12'h010, 1'b1, 6'd63, 1'b1, 4'd1,  CatSingleHit, 4'd0);
    // triple bands
    add_row(12'h00c, 1'b1, 6'd7,  1'b0, '0, '0, '0);
    add_row(12'h00c, 1'b1, 6'd8,  1'b0, '0, '0, '0);
    add_row(12'h00c, 1'b1, 6'd12, 1'b0, '0, '0, '0);
    add_row(12'h00c, 1'b1, 6'd16, 1'b0, '0, '0, '0);
    // single hit bands
    add_row(12'h0c0, 1'b1, 6'd3,  1'b0, '0, '0, '0);
    add_row(12'h0c0, 1'b1, 6'd4,  1'b0, '0, '0, '0);
    add_row(12'h0c0, 1'b1, 6'd8,  1'b0, '0, '0, '0);
    // double bands with an allowed station mode
    add_row(12'h041, 1'b1, 6'd15, 1'b0, '0, '0, '0);
    add_row(12'h041, 1'b1, 6'd16, 1'b0, '0, '0, '0);
    add_row(12'h041, 1'b1, 6'd24, 1'b0, '0, '0, '0);
    add_row(12'h041, 1'b1, 6'd32, 1'b0, '0, '0, '0);
    // double and single with station modes that block the upper bands
    add_row(12'h0c1, 1'b1, 6'd63, 1'b0, '0, '0, '0);
    add_row(12'h006, 1'b1, 6'd63, 1'b0, '0, '0, '0);
    // single bands with an allowed station mode, then invalid
    add_row(12'h00e, 1'b1, 6'd32, 1'b0, '0, '0, '0);
    add_row(12'h00e, 1'b1, 6'd40, 1'b0, '0, '0, '0);
    add_row(12'h00e, 1'b1, 6'd52, 1'b0, '0, '0, '0);
    add_row(12'h00e, 1'b0, 6'd52, 1'b0, '0, '0, '0);

    // reset
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_tracks[i]) begin
      cls = directed_tracks[i].typed ? directed_tracks[i].res
                                     : classify_track(directed_tracks[i].trk);
      send_track(directed_tracks[i].trk, cls);
    end

    // random phases; sender idle chance of 0, 72, 0 and 22 percent
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        1: idle_pct = 72;
        3: idle_pct = 22;
        default: idle_pct = 0;
      endcase
      repeat (ItemsPerPhase) begin
        tmqc_req_t trk;
        trk = random_track();
        send_track(trk, classify_track(trk));
      end
    end
    start_i <= 1'b0;

    // drain
    while (expected_class_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_track_mode_quality_classifier: done, clean");
    end else begin
      $display("tb_track_mode_quality_classifier: done, errors");
    end
    $finish;
  end

endmodule
